// ----- rtl/lpwe_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the LED pulse-width bit encoder.
// No dependencies. Used by every module under rtl.
package lpwe_pkg;

    // default sizing, handed to the top level parameters
    localparam int BITS_PER_CHANNEL_DEF = 8;
    localparam int CHANNEL_COUNT_DEF    = 3;
    localparam int TIMER_WIDTH_DEF      = 12;

    // fixed widths of the config registers, the channel bytes and the APB bus
    localparam int CFG_WIDTH     = 12;
    localparam int BYTE_WIDTH    = 8;
    localparam int APB_DATA_W    = 32;
    localparam int APB_ADDR_W    = 4;

    // register reset values, in ticks
    localparam logic [CFG_WIDTH-1:0] ONE_HIGH_RST  = 12'd120;
    localparam logic [CFG_WIDTH-1:0] ONE_LOW_RST   = 12'd130;
    localparam logic [CFG_WIDTH-1:0] ZERO_HIGH_RST = 12'd50;
    localparam logic [CFG_WIDTH-1:0] ZERO_LOW_RST  = 12'd200;

    // register indexes (paddr[3:2])
    localparam logic [1:0] REG_ONE_HIGH  = 2'd0;
    localparam logic [1:0] REG_ONE_LOW   = 2'd1;
    localparam logic [1:0] REG_ZERO_HIGH = 2'd2;
    localparam logic [1:0] REG_ZERO_LOW  = 2'd3;

    // opcodes
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_LOAD = 1'b1;

    // phase lengths as seen by the encoder
    typedef struct packed {
        logic [CFG_WIDTH-1:0] one_high;
        logic [CFG_WIDTH-1:0] one_low;
        logic [CFG_WIDTH-1:0] zero_high;
        logic [CFG_WIDTH-1:0] zero_low;
    } t_cfg;

    // one result beat
    typedef struct packed {
        logic line_level;
        logic busy_res;
        logic frame_done;
        logic load_rejected;
    } t_result;

endpackage

// ----- rtl/lpwe_cfg_regs.sv -----
`timescale 1ns / 1ps
// APB register file holding the four phase lengths.
// Depends on lpwe_pkg.
module lpwe_cfg_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [lpwe_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [lpwe_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [lpwe_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready,
    output lpwe_pkg::t_cfg                   o_cfg
);

    lpwe_pkg::t_cfg r_cfg;
    logic [1:0]     w_index;
    logic           w_write;
    logic [lpwe_pkg::CFG_WIDTH-1:0] w_wdata;
    logic [lpwe_pkg::CFG_WIDTH-1:0] w_rdata;

    assign pready  = 1'b1;
    assign w_index = paddr[3:2];
    assign w_write = psel && penable && pwrite;
    assign w_wdata = pwdata[lpwe_pkg::CFG_WIDTH-1:0];

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.one_high  <= lpwe_pkg::ONE_HIGH_RST;
            r_cfg.one_low   <= lpwe_pkg::ONE_LOW_RST;
            r_cfg.zero_high <= lpwe_pkg::ZERO_HIGH_RST;
            r_cfg.zero_low  <= lpwe_pkg::ZERO_LOW_RST;
        end else if (w_write) begin
            unique case (w_index)
                lpwe_pkg::REG_ONE_HIGH:  r_cfg.one_high  <= w_wdata;
                lpwe_pkg::REG_ONE_LOW:   r_cfg.one_low   <= w_wdata;
                lpwe_pkg::REG_ZERO_HIGH: r_cfg.zero_high <= w_wdata;
                lpwe_pkg::REG_ZERO_LOW:  r_cfg.zero_low  <= w_wdata;
                default:                 r_cfg.one_high  <= r_cfg.one_high;
            endcase
        end
    end

    // read mux
    always_comb begin
        unique case (w_index)
            lpwe_pkg::REG_ONE_HIGH:  w_rdata = r_cfg.one_high;
            lpwe_pkg::REG_ONE_LOW:   w_rdata = r_cfg.one_low;
            lpwe_pkg::REG_ZERO_HIGH: w_rdata = r_cfg.zero_high;
            lpwe_pkg::REG_ZERO_LOW:  w_rdata = r_cfg.zero_low;
            default:                 w_rdata = '0;
        endcase
    end

    assign prdata = {{(lpwe_pkg::APB_DATA_W - lpwe_pkg::CFG_WIDTH){1'b0}}, w_rdata};
    assign o_cfg  = r_cfg;

endmodule

// ----- rtl/lpwe_encoder.sv -----
`timescale 1ns / 1ps
// Frame shifter, phase timer and per-beat result logic.
// Depends on lpwe_pkg.
module lpwe_encoder #(
    parameter int BITS_PER_CHANNEL = lpwe_pkg::BITS_PER_CHANNEL_DEF,
    parameter int CHANNEL_COUNT    = lpwe_pkg::CHANNEL_COUNT_DEF,
    parameter int TIMER_WIDTH      = lpwe_pkg::TIMER_WIDTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_step,
    input  logic                             i_op,
    input  logic [lpwe_pkg::BYTE_WIDTH-1:0]  i_red,
    input  logic [lpwe_pkg::BYTE_WIDTH-1:0]  i_green,
    input  logic [lpwe_pkg::BYTE_WIDTH-1:0]  i_blue,
    input  lpwe_pkg::t_cfg                   i_cfg,
    output lpwe_pkg::t_result                o_result
);

    localparam int FRAME_BITS = BITS_PER_CHANNEL * CHANNEL_COUNT;
    localparam int REM_W      = $clog2(FRAME_BITS + 1);
    localparam int CMP_W      = ((lpwe_pkg::CFG_WIDTH > TIMER_WIDTH) ?
                                 lpwe_pkg::CFG_WIDTH : TIMER_WIDTH) + 1;
    localparam logic [CMP_W-1:0] LEN_CAP = CMP_W'((64'd1 << TIMER_WIDTH) - 64'd1);
    localparam int EXT_W      = 2 * lpwe_pkg::BYTE_WIDTH;

    logic [FRAME_BITS-1:0]  r_shift, n_shift;
    logic [REM_W-1:0]       r_remain, n_remain;
    logic                   r_high, n_high;
    logic [TIMER_WIDTH-1:0] r_count, n_count;
    logic                   r_active, n_active;

    logic [EXT_W-1:0]            w_ch [CHANNEL_COUNT];
    logic [FRAME_BITS-1:0]       w_frame;
    logic                        w_cur_bit;
    logic [lpwe_pkg::CFG_WIDTH-1:0] w_raw_len;
    logic [CMP_W-1:0]            w_len;
    logic [CMP_W-1:0]            w_cnt_inc;
    logic                        w_phase_end;

    // channel bytes, zero beyond blue
    for (genvar g = 0; g < CHANNEL_COUNT; g++) begin : g_ch
        if (g == 0) begin : g_red
            assign w_ch[g] = EXT_W'(i_red);
        end else if (g == 1) begin : g_green
            assign w_ch[g] = EXT_W'(i_green);
        end else if (g == 2) begin : g_blue
            assign w_ch[g] = EXT_W'(i_blue);
        end else begin : g_zero
            assign w_ch[g] = '0;
        end
    end

    // frame word, first channel at the top
    always_comb begin
        w_frame = '0;
        for (int k = 0; k < CHANNEL_COUNT; k++) begin
            w_frame[(CHANNEL_COUNT-1-k)*BITS_PER_CHANNEL +: BITS_PER_CHANNEL] =
                w_ch[k][BITS_PER_CHANNEL-1:0];
        end
    end

    // current phase length, zero taken as one, capped to the timer
    assign w_cur_bit = r_shift[FRAME_BITS-1];
    always_comb begin
        if (r_high) begin
            w_raw_len = w_cur_bit ? i_cfg.one_high : i_cfg.zero_high;
        end else begin
            w_raw_len = w_cur_bit ? i_cfg.one_low : i_cfg.zero_low;
        end
        w_len = CMP_W'(w_raw_len);
        if (w_len == '0) begin
            w_len = CMP_W'(1);
        end
        if (w_len > LEN_CAP) begin
            w_len = LEN_CAP;
        end
    end

    assign w_cnt_inc   = CMP_W'(r_count) + CMP_W'(1);
    assign w_phase_end = (w_cnt_inc >= w_len);

    // next state and result for one beat
    always_comb begin
        n_shift  = r_shift;
        n_remain = r_remain;
        n_high   = r_high;
        n_count  = r_count;
        n_active = r_active;
        o_result = '0;
        if (i_op == lpwe_pkg::OP_LOAD) begin
            if (r_active) begin
                o_result.line_level    = r_high;
                o_result.busy_res      = 1'b1;
                o_result.load_rejected = 1'b1;
            end else begin
                n_shift  = w_frame;
                n_remain = REM_W'(FRAME_BITS);
                n_high   = 1'b1;
                n_count  = '0;
                n_active = 1'b1;
                o_result.line_level = 1'b1;
                o_result.busy_res   = 1'b1;
            end
        end else if (r_active) begin
            o_result.line_level = r_high;
            o_result.busy_res   = 1'b1;
            if (w_phase_end) begin
                n_count = '0;
                if (r_high) begin
                    n_high = 1'b0;
                end else begin
                    n_shift = r_shift << 1;
                    if (r_remain != '0) begin
                        n_remain = r_remain - REM_W'(1);
                    end
                    if (n_remain == '0) begin
                        n_active = 1'b0;
                        o_result.frame_done = 1'b1;
                    end else begin
                        n_high = 1'b1;
                    end
                end
            end else begin
                n_count = w_cnt_inc[TIMER_WIDTH-1:0];
            end
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift  <= '0;
            r_remain <= '0;
            r_high   <= 1'b0;
            r_count  <= '0;
            r_active <= 1'b0;
        end else if (i_step) begin
            r_shift  <= n_shift;
            r_remain <= n_remain;
            r_high   <= n_high;
            r_count  <= n_count;
            r_active <= n_active;
        end
    end

    // idle means no bits left to send
    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_active |-> (r_remain == '0))
        else $error("idle with bits remaining");

    // a frame ends only with a done beat
    a_end_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && r_active && !n_active) |-> o_result.frame_done)
        else $error("frame ended without done");

    // reject only while sending
    a_reject_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && o_result.load_rejected) |-> r_active)
        else $error("load rejected while idle");

    // an accepted load starts a frame in its high phase
    a_load_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && i_op == lpwe_pkg::OP_LOAD && !r_active) |=>
            (r_active && r_high && r_count == '0))
        else $error("load did not start frame");

endmodule

// ----- rtl/led_pulse_width_bit_encoder_unit.sv -----
`timescale 1ns / 1ps
// Top level of the LED pulse-width bit encoder: channels, result register.
// Depends on lpwe_pkg, lpwe_cfg_regs and lpwe_encoder.
//
//  channel | handshake                 | payload
//  --------+---------------------------+--------------------------------------
//  input   | i_in_valid / o_in_stall   | i_op, i_red, i_green, i_blue
//  output  | o_out_valid / i_out_stall | o_line_level, o_busy_res,
//          |                           | o_frame_done, o_load_rejected
//  config  | psel, penable, pwrite     | paddr, pwdata, prdata, pready
//
// One beat in each clock while the input is not stalled; its result is registered and shows in the cycle after.
// Each beat is worked by the combinational encoder logic feeding the result register.
// Synchronous active-low reset clears all control state; registers return to defaults.
// The input stalls only while a held result is stalled; a taken result frees it.
module led_pulse_width_bit_encoder_unit #(
    parameter int BITS_PER_CHANNEL = lpwe_pkg::BITS_PER_CHANNEL_DEF,
    parameter int CHANNEL_COUNT    = lpwe_pkg::CHANNEL_COUNT_DEF,
    parameter int TIMER_WIDTH      = lpwe_pkg::TIMER_WIDTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // input beats
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic                             i_op,
    input  logic [lpwe_pkg::BYTE_WIDTH-1:0]  i_red,
    input  logic [lpwe_pkg::BYTE_WIDTH-1:0]  i_green,
    input  logic [lpwe_pkg::BYTE_WIDTH-1:0]  i_blue,
    // result beats
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic                             o_line_level,
    output logic                             o_busy_res,
    output logic                             o_frame_done,
    output logic                             o_load_rejected,
    // register port
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [lpwe_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [lpwe_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [lpwe_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready
);

    lpwe_pkg::t_cfg    w_cfg;
    lpwe_pkg::t_result w_result;
    lpwe_pkg::t_result r_result;
    logic              r_out_valid;
    logic              w_accept;

    lpwe_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    lpwe_encoder #(
        .BITS_PER_CHANNEL (BITS_PER_CHANNEL),
        .CHANNEL_COUNT    (CHANNEL_COUNT),
        .TIMER_WIDTH      (TIMER_WIDTH)
    ) u_enc (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_accept),
        .i_op     (i_op),
        .i_red    (i_red),
        .i_green  (i_green),
        .i_blue   (i_blue),
        .i_cfg    (w_cfg),
        .o_result (w_result)
    );

    // accept unless a held result is stalled
    assign o_in_stall = r_out_valid && i_out_stall;
    assign w_accept   = i_in_valid && !o_in_stall;

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_result <= w_result;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_line_level    = r_result.line_level;
    assign o_busy_res      = r_result.busy_res;
    assign o_frame_done    = r_result.frame_done;
    assign o_load_rejected = r_result.load_rejected;

endmodule
